/* sv/length_framed_byte_ring_top_defines.svh */
// Assertion helpers for the length framed byte ring.
// Each macro assumes i_clk and i_rst_n are visible where it is used.
`ifndef LENGTH_FRAMED_BYTE_RING_TOP_DEFINES_SVH
`define LENGTH_FRAMED_BYTE_RING_TOP_DEFINES_SVH

// Check a consequence in the same cycle.
`define LFBR_AST_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the next cycle.
`define LFBR_AST_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/lfbr_pkg.sv */
package lfbr_pkg;

    // Ring geometry
    localparam int RING_BYTES   = 4096;
    localparam int OFF_W        = $clog2(RING_BYTES);
    localparam int CNT_W        = $clog2(RING_BYTES + 1);

    // Field widths
    localparam int CFG_W        = 13;
    localparam int LEN_W        = 16;
    localparam int DROP_W       = 32;
    localparam int PREFIX_W     = 32;
    localparam int PREFIX_BYTES = 4;
    localparam int PCNT_W       = $clog2(PREFIX_BYTES + 1);
    localparam int MIN_LEN      = 5;

    // Configuration port
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;
    localparam logic REG_RING_SIZE = 1'b0;

    // Operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef enum logic [2:0] {
        ST_STORED  = 3'd0,
        ST_DISCARD = 3'd1,
        ST_ZERO    = 3'd2,
        ST_BYTE    = 3'd3,
        ST_NONE    = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_WR_FIRST,
        S_WR_BYTE,
        S_RD_CHECK,
        S_PEEK,
        S_EVAL,
        S_FETCH,
        S_DATA,
        S_RESP
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic latch;
        logic wr_first;
        logic wr_byte;
        logic peek_start;
        logic peek_issue;
        logic peek_capture;
        logic skip;
        logic take_len;
        logic fetch_issue;
        logic read_byte;
        logic set_none;
        logic out_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_read;
        logic first;
        logic len_zero;
        logic rd_rem_nz;
        logic cu_ge4;
        logic cu_nz;
        logic prefix_bad;
        logic prefix_fits;
    } t_stat;

endpackage

/* sv/lfbr_ifs.sv */
// Input word channel
interface lfbr_item_if import lfbr_pkg::*;;
    logic             valid;
    logic             ready;
    logic             operation;
    logic             first_byte;
    logic [LEN_W-1:0] message_length;
    logic [7:0]       in_byte;

    modport source (output valid, operation, first_byte, message_length, in_byte,
                    input ready);
    modport sink   (input valid, operation, first_byte, message_length, in_byte,
                    output ready);
endinterface

// Result word channel
interface lfbr_res_if import lfbr_pkg::*;;
    logic              valid;
    logic              ready;
    logic [2:0]        status;
    logic [7:0]        out_byte;
    logic              end_of_message;
    logic [DROP_W-1:0] drop_total;

    modport source (output valid, status, out_byte, end_of_message, drop_total,
                    input ready);
    modport sink   (input valid, status, out_byte, end_of_message, drop_total,
                    output ready);
endinterface

/* sv/lfbr_ctrl.sv */
module lfbr_ctrl import lfbr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state              r_state, n_state;
    logic [PCNT_W-1:0]   r_cnt, n_cnt;
    logic                r_out_valid, n_out_valid;

    // State, prefix byte count and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = (r_out_valid && !i_out_ready) ? 1'b1 : 1'b0;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_stat.is_read) begin
                    n_state = S_RD_CHECK;
                end else if (i_stat.first) begin
                    n_state = S_WR_FIRST;
                end else begin
                    n_state = S_WR_BYTE;
                end
            end
            S_WR_FIRST: begin
                o_cmd.wr_first = 1'b1;
                n_state = i_stat.len_zero ? S_RESP : S_WR_BYTE;
            end
            S_WR_BYTE: begin
                o_cmd.wr_byte = 1'b1;
                n_state = S_RESP;
            end
            S_RD_CHECK: begin
                if (i_stat.rd_rem_nz) begin
                    n_state = S_FETCH;
                end else if (i_stat.cu_ge4) begin
                    o_cmd.peek_start = 1'b1;
                    n_cnt   = '0;
                    n_state = S_PEEK;
                end else begin
                    o_cmd.set_none = 1'b1;
                    n_state = S_RESP;
                end
            end
            S_PEEK: begin
                // Issue one address a cycle, capture each byte in the cycle after its issue
                o_cmd.peek_issue   = (r_cnt < PCNT_W'(PREFIX_BYTES));
                o_cmd.peek_capture = (r_cnt != '0);
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == PCNT_W'(PREFIX_BYTES)) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_stat.prefix_bad) begin
                    o_cmd.skip = 1'b1;
                    n_state = S_RD_CHECK;
                end else if (i_stat.prefix_fits) begin
                    o_cmd.take_len = 1'b1;
                    n_state = S_FETCH;
                end else begin
                    o_cmd.set_none = 1'b1;
                    n_state = S_RESP;
                end
            end
            S_FETCH: begin
                o_cmd.fetch_issue = 1'b1;
                n_state = S_DATA;
            end
            S_DATA: begin
                o_cmd.read_byte = 1'b1;
                n_state = S_RESP;
            end
            S_RESP: begin
                // Hold until the result register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

/* sv/lfbr_dp.sv */
module lfbr_dp import lfbr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic                  i_operation,
    input  logic                  i_first_byte,
    input  logic [LEN_W-1:0]      i_message_length,
    input  logic [7:0]            i_in_byte,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [2:0]            o_status,
    output logic [7:0]            o_out_byte,
    output logic                  o_end_of_message,
    output logic [DROP_W-1:0]     o_drop_total
);

    // Ring memory
    logic [7:0]          r_ring [RING_BYTES];

    // Ring bookkeeping
    logic [CNT_W-1:0]    r_size;
    logic [OFF_W-1:0]    r_wr_off, r_cm_off, r_rd_off, r_peek_off;
    logic [CNT_W-1:0]    r_res_used, r_cm_used, r_rd_rem;
    logic [LEN_W-1:0]    r_wr_rem;
    logic                r_dropping;
    logic [DROP_W-1:0]   r_drops;

    // Latched word and working values
    logic                r_op, r_first;
    logic [LEN_W-1:0]    r_len;
    logic [7:0]          r_byte;
    logic [PREFIX_W-1:0] r_prefix;
    logic [7:0]          r_rd_data;
    t_status             r_res_status;
    logic [7:0]          r_res_byte;
    logic                r_res_eom;
    t_status             r_o_status;
    logic [7:0]          r_o_byte;
    logic                r_o_eom;
    logic [DROP_W-1:0]   r_o_drops;

    logic                cfg_we;
    logic [CFG_W-1:0]    cfg_val;
    logic [CNT_W-1:0]    cfg_size;
    logic [CNT_W-1:0]    free_space;
    logic                no_room;
    logic [LEN_W-1:0]    n_wr_rem;
    logic [OFF_W-1:0]    n_wr_off;
    logic [OFF_W-1:0]    n_rd_off;
    logic                mem_we;
    logic                mem_re;
    logic [OFF_W-1:0]    mem_raddr;
    logic                read_one;

    function automatic logic [OFF_W-1:0] f_next(input logic [OFF_W-1:0] off,
                                                input logic [CNT_W-1:0] size);
        logic [CNT_W-1:0] n;
        n = CNT_W'(off) + 1'b1;
        return (n >= size) ? '0 : n[OFF_W-1:0];
    endfunction

    // Register port: clamp ring size into its legal range
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && (paddr[2] == REG_RING_SIZE);
    assign cfg_val = pwdata[CFG_W-1:0];
    always_comb begin
        if (32'(cfg_val) < 32'(MIN_LEN)) begin
            cfg_size = CNT_W'(MIN_LEN);
        end else if (32'(cfg_val) > 32'(RING_BYTES)) begin
            cfg_size = CNT_W'(RING_BYTES);
        end else begin
            cfg_size = CNT_W'(cfg_val);
        end
    end
    assign prdata = (paddr[2] == REG_RING_SIZE) ? APB_DATA_W'(r_size) : '0;

    // Space check and write byte step
    assign free_space = r_size - r_cm_used;
    assign no_room    = 32'(free_space) < 32'(r_len);
    assign n_wr_rem   = r_wr_rem - 1'b1;
    assign n_wr_off   = f_next(r_wr_off, r_size);
    assign n_rd_off   = f_next(r_rd_off, r_size);
    assign mem_we     = i_cmd.wr_byte && (r_wr_rem != '0) && !r_dropping;
    assign read_one   = i_cmd.skip || i_cmd.read_byte;

    // Memory read port: prefix peek or read cursor
    assign mem_re    = i_cmd.peek_issue || i_cmd.fetch_issue;
    assign mem_raddr = i_cmd.peek_issue ? r_peek_off : r_rd_off;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_ring[r_wr_off] <= r_byte;
        end
        if (mem_re) begin
            r_rd_data <= r_ring[mem_raddr];
        end
    end

    // Status to controller
    always_comb begin
        o_stat.is_read     = (r_op == OP_READ);
        o_stat.first       = r_first;
        o_stat.len_zero    = (r_len == '0);
        o_stat.rd_rem_nz   = (r_rd_rem != '0);
        o_stat.cu_ge4      = (r_cm_used >= CNT_W'(PREFIX_BYTES));
        o_stat.cu_nz       = (r_cm_used != '0);
        o_stat.prefix_bad  = (r_prefix < PREFIX_W'(MIN_LEN))
                          || (r_prefix > PREFIX_W'(r_size));
        o_stat.prefix_fits = (r_cm_used >= r_prefix[CNT_W-1:0]);
    end

    // Ring state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size     <= CNT_W'(RING_BYTES);
            r_wr_off   <= '0;
            r_cm_off   <= '0;
            r_rd_off   <= '0;
            r_res_used <= '0;
            r_cm_used  <= '0;
            r_wr_rem   <= '0;
            r_dropping <= 1'b0;
            r_rd_rem   <= '0;
            r_drops    <= '0;
        end else begin
            // Restart from the last commit, reserve or drop
            if (i_cmd.wr_first) begin
                r_wr_off   <= r_cm_off;
                r_wr_rem   <= r_len;
                r_dropping <= (r_len != '0) && no_room;
                if ((r_len != '0) && no_room) begin
                    r_res_used <= r_cm_used;
                    r_drops    <= r_drops + 1'b1;
                end else if (r_len != '0) begin
                    r_res_used <= r_cm_used + CNT_W'(r_len);
                end else begin
                    r_res_used <= r_cm_used;
                end
            end
            // Store or discard one byte, commit on the last
            if (i_cmd.wr_byte && (r_wr_rem != '0)) begin
                r_wr_rem <= n_wr_rem;
                if (r_dropping) begin
                    if (n_wr_rem == '0) begin
                        r_dropping <= 1'b0;
                    end
                end else begin
                    r_wr_off <= n_wr_off;
                    if (n_wr_rem == '0) begin
                        r_cm_off  <= n_wr_off;
                        r_cm_used <= r_res_used;
                    end
                end
            end
            // Consume one byte from the read side
            if (read_one) begin
                r_rd_off <= n_rd_off;
                if (r_cm_used != '0) begin
                    r_cm_used <= r_cm_used - 1'b1;
                end
                if (r_res_used != '0) begin
                    r_res_used <= r_res_used - 1'b1;
                end
            end
            if (i_cmd.take_len) begin
                r_rd_rem <= r_prefix[CNT_W-1:0];
            end
            if (i_cmd.read_byte) begin
                r_rd_rem <= r_rd_rem - 1'b1;
            end
            // Size write empties the ring, keeps the drop count
            if (cfg_we) begin
                r_size     <= cfg_size;
                r_wr_off   <= '0;
                r_cm_off   <= '0;
                r_rd_off   <= '0;
                r_res_used <= '0;
                r_cm_used  <= '0;
                r_wr_rem   <= '0;
                r_dropping <= 1'b0;
                r_rd_rem   <= '0;
            end
        end
    end

    // Latched word, prefix, pending result and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op    <= i_operation;
            r_first <= i_first_byte;
            r_len   <= i_message_length;
            r_byte  <= i_in_byte;
        end
        if (i_cmd.peek_start) begin
            r_peek_off <= r_rd_off;
        end
        if (i_cmd.peek_issue) begin
            r_peek_off <= f_next(r_peek_off, r_size);
        end
        if (i_cmd.peek_capture) begin
            r_prefix <= {r_rd_data, r_prefix[PREFIX_W-1:8]};
        end
        if (i_cmd.wr_first) begin
            r_res_status <= ST_ZERO;
            r_res_byte   <= '0;
            r_res_eom    <= 1'b0;
        end
        if (i_cmd.wr_byte) begin
            r_res_status <= ((r_wr_rem == '0) || r_dropping) ? ST_DISCARD : ST_STORED;
            r_res_byte   <= '0;
            r_res_eom    <= 1'b0;
        end
        if (i_cmd.set_none) begin
            r_res_status <= ST_NONE;
            r_res_byte   <= '0;
            r_res_eom    <= 1'b0;
        end
        if (i_cmd.read_byte) begin
            r_res_status <= ST_BYTE;
            r_res_byte   <= r_rd_data;
            r_res_eom    <= (r_rd_rem == CNT_W'(1));
        end
        if (i_cmd.out_load) begin
            r_o_status <= r_res_status;
            r_o_byte   <= r_res_byte;
            r_o_eom    <= r_res_eom;
            r_o_drops  <= r_drops;
        end
    end

    assign o_status         = r_o_status;
    assign o_out_byte       = r_o_byte;
    assign o_end_of_message = r_o_eom;
    assign o_drop_total     = r_o_drops;

endmodule

/* sv/length_framed_byte_ring_top.sv */
// Channel   Dir  Word
// i_item    in   operation, first_byte, message_length, in_byte
// o_res     out  status, out_byte, end_of_message, drop_total
// APB       in   ring size register at byte address 0
//
// One word at a time. A write passes dispatch, a restart step on a first byte, then a byte
// step before its result; a zero-length first byte skips the byte step. A read inside a
// message fetches one byte at the read cursor; starting a message first peeks the four-byte
// prefix through the single read port, and each resync skip drops a byte and peeks again.
// Reset is synchronous; ring contents are not cleared, only offsets and counts.
// One result register: a new word is accepted while the last result waits, and the
// result is held until o_res.ready.
`include "length_framed_byte_ring_top_defines.svh"

module length_framed_byte_ring_top import lfbr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    lfbr_item_if.sink             i_item,
    lfbr_res_if.source            o_res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // Sequencer
    lfbr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // Ring memory and bookkeeping
    lfbr_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_operation      (i_item.operation),
        .i_first_byte     (i_item.first_byte),
        .i_message_length (i_item.message_length),
        .i_in_byte        (i_item.in_byte),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .o_status         (o_res.status),
        .o_out_byte       (o_res.out_byte),
        .o_end_of_message (o_res.end_of_message),
        .o_drop_total     (o_res.drop_total)
    );

    // Checks
    `LFBR_AST_NXT(a_load_shows, w_cmd.out_load, o_res.valid, "loaded result not presented")
    `LFBR_AST_NXT(a_no_early_load, i_item.valid && i_item.ready, !w_cmd.out_load, "result loaded with accept")
    `LFBR_AST_IMP(a_read_has_data, w_cmd.read_byte, w_stat.cu_nz, "byte read from empty ring")
    `LFBR_AST_IMP(a_quiet_payload, o_res.valid && (o_res.status != ST_BYTE), (o_res.out_byte == 8'h00) && !o_res.end_of_message, "byte fields set without a read")

endmodule
